// File: sv/pvh_pkg.sv
// ----------------------------------------------------------------------------
// pvh_pkg - particle velocity histogram shared definitions
// Widths, register indexes, reset values and the queue command flags.
// ----------------------------------------------------------------------------
`default_nettype none

package pvh_pkg;

  localparam int BINS_DEFAULT        = 64;
  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH         = 4;

  localparam int TYPE_W      = 8;
  localparam int VEL_W       = 16;
  localparam int SCALE_W     = 16;
  localparam int MODE_W      = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_INDEX_W = 6;
  localparam int OUT_COUNT_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_MODE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_SCALE      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_TYPE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_SPEED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_X     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_Y     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_Z     = 2'd3;

  localparam logic [MODE_W-1:0]  AXIS_MODE_RESET      = MODE_SPEED;
  localparam logic [SCALE_W-1:0] BIN_SCALE_RESET      = 16'd2560;
  localparam logic [TYPE_W-1:0]  REFERENCE_TYPE_RESET = 8'd14;

  typedef struct packed {
    logic count_en;
    logic ref_en;
    logic last;
  } cmd_flags_t;

endpackage

`default_nettype wire

// File: sv/particle_velocity_histogram.sv
// ----------------------------------------------------------------------------
// particle_velocity_histogram - fixed-width histogram of particle velocities
// Bins speed or one velocity component per particle; reads out on last.
// ----------------------------------------------------------------------------
//  channel  | handshake           | beat
//  ---------+---------------------+-------------------------------------------
//  in       | in_valid / in_stall | particle_type pinned vel_x/y/z last_particle
//  out      | out_valid/out_stall | bin_index bin_count last_bin empty_res
//  cfg      | cfg_write           | cfg_index cfg_data
//
//  Classifier: speed mode runs serial squares, a 16-step root and the scale
//  multiply; component mode only the scale multiply; a fixed particle is queued.
//  Count engine: counted particles get a count RAM read and write; others do not.
//  Readout: each bin is read, then loaded into out; then the count RAM is cleared.
//  After reset the count RAM is cleared; in_stall is high meanwhile.
//  A 4-entry queue decouples the two halves; out has its own output register.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_velocity_histogram #(
  parameter int BINS = pvh_pkg::BINS_DEFAULT,
  parameter int COUNT_WIDTH = pvh_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [pvh_pkg::TYPE_W-1:0]         particle_type,
  input  wire logic                               pinned,
  input  wire logic signed [pvh_pkg::VEL_W-1:0]   vel_x,
  input  wire logic signed [pvh_pkg::VEL_W-1:0]   vel_y,
  input  wire logic signed [pvh_pkg::VEL_W-1:0]   vel_z,
  input  wire logic                               last_particle,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [pvh_pkg::OUT_INDEX_W-1:0]         bin_index,
  output logic [pvh_pkg::OUT_COUNT_W-1:0]         bin_count,
  output logic                                    last_bin,
  output logic                                    empty_res,
  input  wire logic                               cfg_write,
  input  wire logic [pvh_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [pvh_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pvh_pkg::*;

  localparam int BW  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int QW  = $bits(cmd_flags_t) + BW;

  logic [MODE_W-1:0]  axis_mode;
  logic [SCALE_W-1:0] bin_scale;
  logic [TYPE_W-1:0]  reference_type;

  logic               push;
  cmd_flags_t         push_flags;
  logic [BW-1:0]      push_bin;
  logic               full;
  logic               pop;
  logic               empty;
  logic [QW-1:0]      pop_data;
  cmd_flags_t         pop_flags;
  logic [BW-1:0]      pop_bin;
  logic               init_busy;

  assign pop_flags = cmd_flags_t'(pop_data[QW-1:BW]);
  assign pop_bin   = pop_data[BW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_mode      <= AXIS_MODE_RESET;
      bin_scale      <= BIN_SCALE_RESET;
      reference_type <= REFERENCE_TYPE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_AXIS_MODE:      axis_mode      <= cfg_data[MODE_W-1:0];
        REG_BIN_SCALE:      bin_scale      <= cfg_data[SCALE_W-1:0];
        REG_REFERENCE_TYPE: reference_type <= cfg_data[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  pvh_front #(.BINS(BINS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .particle_type  (particle_type),
    .pinned         (pinned),
    .vel_x          (vel_x),
    .vel_y          (vel_y),
    .vel_z          (vel_z),
    .last_particle  (last_particle),
    .axis_mode      (axis_mode),
    .bin_scale      (bin_scale),
    .reference_type (reference_type),
    .hold           (init_busy),
    .push           (push),
    .push_flags     (push_flags),
    .push_bin       (push_bin),
    .full           (full)
  );

  pvh_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_flags, push_bin}),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  pvh_back #(.BINS(BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop       (pop),
    .flags     (pop_flags),
    .bin       (pop_bin),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bin_index (bin_index),
    .bin_count (bin_count),
    .last_bin  (last_bin),
    .empty_res (empty_res),
    .init_busy (init_busy)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("classifier took a second beat while busy");

  a_empty_result_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> last_bin && (bin_count == '0) && (bin_index == '0))
    else $error("empty result not a lone final zero beat");

  a_no_output_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !out_valid && in_stall)
    else $error("activity during post-reset clear");
`endif

endmodule

`default_nettype wire

// File: sv/pvh_fifo.sv
// ----------------------------------------------------------------------------
// pvh_fifo - command queue
// Small register queue between the classifier and the count engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pvh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pvh_pkg::QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);
  import pvh_pkg::*;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CNTW-1:0]  fill;
  logic             do_push;
  logic             do_pop;

  assign full     = (fill == CNTW'(DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        slots[wptr] <= push_data;
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/pvh_front.sv
// ----------------------------------------------------------------------------
// pvh_front - particle classifier
// Accepts a particle, forms speed or component, scales it and queues the bin.
// ----------------------------------------------------------------------------
`default_nettype none

module pvh_front #(
  parameter int BINS = pvh_pkg::BINS_DEFAULT,
  localparam int BW = (BINS > 1) ? $clog2(BINS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [pvh_pkg::TYPE_W-1:0]  particle_type,
  input  wire logic                        pinned,
  input  wire logic signed [pvh_pkg::VEL_W-1:0] vel_x,
  input  wire logic signed [pvh_pkg::VEL_W-1:0] vel_y,
  input  wire logic signed [pvh_pkg::VEL_W-1:0] vel_z,
  input  wire logic                        last_particle,
  input  wire logic [pvh_pkg::MODE_W-1:0]  axis_mode,
  input  wire logic [pvh_pkg::SCALE_W-1:0] bin_scale,
  input  wire logic [pvh_pkg::TYPE_W-1:0]  reference_type,
  input  wire logic                        hold,
  output logic                             push,
  output pvh_pkg::cmd_flags_t              push_flags,
  output logic [BW-1:0]                    push_bin,
  input  wire logic                        full
);
  import pvh_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_ROOT, S_MUL, S_BIN} state_t;

  state_t                   state;
  logic signed [VEL_W-1:0]  vx;
  logic signed [VEL_W-1:0]  vy;
  logic signed [VEL_W-1:0]  vz;
  logic                     is_ref;
  logic                     skip;
  logic                     last;
  logic [1:0]               sq_cnt;
  logic [3:0]               root_cnt;
  logic [31:0]              rem;
  logic [31:0]              root;
  logic [31:0]              bbit;
  logic signed [33:0]       prod;

  logic signed [VEL_W-1:0]  comp;
  logic signed [16:0]       mul_a;
  logic signed [16:0]       mul_b;
  logic [31:0]              trial;
  logic [17:0]              bin_hi;
  logic                     neg;
  logic                     over;
  logic                     accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || hold;

  always_comb begin
    comp = vz;
    if (state == S_SQ) begin
      case (sq_cnt)
        2'd0:    comp = vx;
        2'd1:    comp = vy;
        default: comp = vz;
      endcase
    end else begin
      case (axis_mode)
        MODE_X:  comp = vx;
        MODE_Y:  comp = vy;
        default: comp = vz;
      endcase
    end
  end

  always_comb begin
    if (state == S_SQ) begin
      mul_a = {comp[VEL_W-1], comp};
      mul_b = {comp[VEL_W-1], comp};
    end else begin
      mul_a = (axis_mode == MODE_SPEED) ? {1'b0, root[15:0]} : {comp[VEL_W-1], comp};
      mul_b = {1'b0, bin_scale};
    end
  end

  assign trial  = root + bbit;
  assign bin_hi = prod[33:16];
  assign neg    = prod[33];
  assign over   = !neg && (bin_hi > 18'(BINS - 1));

  assign push                = (state == S_BIN) && !full;
  assign push_flags.count_en = !skip && !neg && !over;
  assign push_flags.ref_en   = is_ref;
  assign push_flags.last     = last;
  assign push_bin            = neg ? '0 : (over ? BW'(BINS - 1) : prod[16 +: BW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            vx     <= vel_x;
            vy     <= vel_y;
            vz     <= vel_z;
            last   <= last_particle;
            skip   <= pinned;
            is_ref <= !pinned && (particle_type == reference_type);
            rem    <= '0;
            sq_cnt <= '0;
            if (pinned) begin
              state <= S_BIN;
            end else if (axis_mode == MODE_SPEED) begin
              state <= S_SQ;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_SQ: begin
          prod   <= mul_a * mul_b;
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt != 2'd0) begin
            rem <= rem + prod[31:0];
          end
          if (sq_cnt == 2'd3) begin
            root     <= '0;
            bbit     <= 32'h4000_0000;
            root_cnt <= '0;
            state    <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (rem >= trial) begin
            rem  <= rem - trial;
            root <= (root >> 1) + bbit;
          end else begin
            root <= root >> 1;
          end
          bbit     <= bbit >> 2;
          root_cnt <= root_cnt + 1'b1;
          if (root_cnt == 4'd15) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_BIN;
        end
        S_BIN: begin
          if (!full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/pvh_back.sv
// ----------------------------------------------------------------------------
// pvh_back - count engine and readout
// Updates the count store, tracks the reference maximum, reads out and clears.
// ----------------------------------------------------------------------------
`default_nettype none

module pvh_back #(
  parameter int BINS = pvh_pkg::BINS_DEFAULT,
  parameter int COUNT_WIDTH = pvh_pkg::COUNT_WIDTH_DEFAULT,
  localparam int BW = (BINS > 1) ? $clog2(BINS) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            empty,
  output logic                                 pop,
  input  wire pvh_pkg::cmd_flags_t             flags,
  input  wire logic [BW-1:0]                   bin,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [pvh_pkg::OUT_INDEX_W-1:0]      bin_index,
  output logic [pvh_pkg::OUT_COUNT_W-1:0]      bin_count,
  output logic                                 last_bin,
  output logic                                 empty_res,
  output logic                                 init_busy
);
  import pvh_pkg::*;

  typedef enum logic [3:0] {
    B_INIT, B_IDLE, B_RD, B_WR, B_CHK, B_EMPTY, B_RO_RD, B_RO_LD, B_CLR
  } state_t;

  state_t                 state;
  logic [COUNT_WIDTH-1:0] counts [BINS];
  logic [COUNT_WIDTH-1:0] rdata;
  logic [BW-1:0]          cur_bin;
  logic                   cur_last;
  logic [BW-1:0]          max_bin;
  logic                   ref_seen;
  logic [BW-1:0]          k;
  logic [BW-1:0]          clr_addr;

  logic                   we;
  logic                   re;
  logic [BW-1:0]          waddr;
  logic [BW-1:0]          raddr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [COUNT_WIDTH-1:0] inc;
  logic [31:0]            cnt_wide;
  logic [31:0]            idx_wide;
  logic                   out_free;
  logic                   out_load;

  assign pop       = (state == B_IDLE) && !empty;
  assign init_busy = (state == B_INIT);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = ((state == B_EMPTY) || (state == B_RO_LD)) && out_free;
  assign inc       = (rdata == {COUNT_WIDTH{1'b1}}) ? rdata : rdata + 1'b1;
  assign cnt_wide  = 32'(rdata);
  assign idx_wide  = 32'(k);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = clr_addr;
    raddr = cur_bin;
    wdata = '0;
    case (state)
      B_INIT, B_CLR: we = 1'b1;
      B_RD: re = 1'b1;
      B_WR: begin
        we    = 1'b1;
        waddr = cur_bin;
        wdata = inc;
      end
      B_RO_RD: begin
        re    = 1'b1;
        raddr = k;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      counts[waddr] <= wdata;
    end
    if (re) begin
      rdata <= counts[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      clr_addr  <= '0;
      ref_seen  <= 1'b0;
      max_bin   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_INIT, B_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BW'(BINS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty) begin
            cur_bin  <= bin;
            cur_last <= flags.last;
            if (flags.ref_en) begin
              ref_seen <= 1'b1;
              if (!ref_seen || bin > max_bin) begin
                max_bin <= bin;
              end
            end
            if (flags.count_en) begin
              state <= B_RD;
            end else if (flags.last) begin
              state <= B_CHK;
            end
          end
        end
        B_RD: state <= B_WR;
        B_WR: state <= cur_last ? B_CHK : B_IDLE;
        B_CHK: begin
          k     <= '0;
          state <= ref_seen ? B_RO_RD : B_EMPTY;
        end
        B_EMPTY: begin
          if (out_free) begin
            bin_index <= '0;
            bin_count <= '0;
            last_bin  <= 1'b1;
            empty_res <= 1'b1;
            clr_addr  <= '0;
            ref_seen  <= 1'b0;
            max_bin   <= '0;
            state     <= B_CLR;
          end
        end
        B_RO_RD: state <= B_RO_LD;
        B_RO_LD: begin
          if (out_free) begin
            bin_index <= idx_wide[OUT_INDEX_W-1:0];
            bin_count <= (cnt_wide > 32'hFFFF) ? {OUT_COUNT_W{1'b1}}
                                               : cnt_wide[OUT_COUNT_W-1:0];
            last_bin  <= (k == max_bin);
            empty_res <= 1'b0;
            if (k == max_bin) begin
              clr_addr <= '0;
              ref_seen <= 1'b0;
              max_bin  <= '0;
              state    <= B_CLR;
            end else begin
              k     <= k + 1'b1;
              state <= B_RO_RD;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: bench/particle_velocity_histogram_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_velocity_histogram_checker - histogram predictor and beat compare
// Watches the particle, result and register ports of the histogram block,
// keeps its own copy of the registers and bin counts, works out the bins each
// readout must emit and compares every result beat, field by field, with the
// oldest one still owed. Mismatches are printed and counted.
// ----------------------------------------------------------------------------
module particle_velocity_histogram_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [pvh_pkg::TYPE_W-1:0]           particle_type,
  input  logic                                 pinned,
  input  logic signed [pvh_pkg::VEL_W-1:0]     vel_x,
  input  logic signed [pvh_pkg::VEL_W-1:0]     vel_y,
  input  logic signed [pvh_pkg::VEL_W-1:0]     vel_z,
  input  logic                                 last_particle,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [pvh_pkg::OUT_INDEX_W-1:0]      bin_index,
  input  logic [pvh_pkg::OUT_COUNT_W-1:0]      bin_count,
  input  logic                                 last_bin,
  input  logic                                 empty_res,
  input  logic                                 cfg_write,
  input  logic [pvh_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pvh_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                   errors,
  output int                                   pending,
  output int                                   results
);
  import pvh_pkg::*;

  localparam int NBINS = BINS_DEFAULT;

  typedef struct packed {
    logic [OUT_INDEX_W-1:0] index;
    logic [OUT_COUNT_W-1:0] count;
    logic                   closing;
    logic                   no_ref;
  } bin_beat_t;

  bin_beat_t              bins_due[$];
  logic [OUT_COUNT_W-1:0] tally[NBINS];
  int                     top_bin;
  bit                     ref_seen;
  logic [MODE_W-1:0]      axis;
  logic [SCALE_W-1:0]     scale;
  logic [TYPE_W-1:0]      ref_kind;

  initial begin
    errors = 0;
    pending = 0;
    results = 0;
  end

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  task automatic clear_histogram();
    foreach (tally[k]) tally[k] = '0;
    top_bin = 0;
    ref_seen = 0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic fold_particle();
    longint    vx, vy, vz, v, sc, bin;
    int        clamped;
    bin_beat_t b;
    vx = vel_x;
    vy = vel_y;
    vz = vel_z;
    sc = scale;
    if (!pinned) begin
      case (axis)
        MODE_SPEED: v = longint'(root_floor(vx * vx + vy * vy + vz * vz));
        MODE_X:     v = vx;
        MODE_Y:     v = vy;
        default:    v = vz;
      endcase
      // floor of value * scale / 2^16, toward minus infinity
      bin = (v * sc) >>> 16;
      if (bin >= 0 && bin < NBINS) begin
        if (tally[int'(bin)] != {OUT_COUNT_W{1'b1}}) tally[int'(bin)]++;
      end
      if (particle_type == ref_kind) begin
        if (bin < 0) clamped = 0;
        else if (bin > NBINS - 1) clamped = NBINS - 1;
        else clamped = int'(bin);
        if (!ref_seen || clamped > top_bin) top_bin = clamped;
        ref_seen = 1;
      end
    end
    if (last_particle) begin
      if (!ref_seen) begin
        b.index = '0;
        b.count = '0;
        b.closing = 1'b1;
        b.no_ref = 1'b1;
        bins_due.push_back(b);
      end else begin
        for (int k = 0; k <= top_bin; k++) begin
          b.index = OUT_INDEX_W'(k);
          b.count = tally[k];
          b.closing = (k == top_bin);
          b.no_ref = 1'b0;
          bins_due.push_back(b);
        end
      end
      clear_histogram();
    end
  endtask

  task automatic compare_beat();
    bin_beat_t want;
    results++;
    if (bins_due.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing owed: bin_index %0d bin_count %0d",
                                bin_index, bin_count));
    end else begin
      want = bins_due.pop_front();
      if (bin_index !== want.index)
        report_mismatch($sformatf("bin_index %0d, expected %0d", bin_index, want.index));
      if (bin_count !== want.count)
        report_mismatch($sformatf("bin_count %0d, expected %0d (bin %0d)",
                                  bin_count, want.count, want.index));
      if (last_bin !== want.closing)
        report_mismatch($sformatf("last_bin %b, expected %b (bin %0d)",
                                  last_bin, want.closing, want.index));
      if (empty_res !== want.no_ref)
        report_mismatch($sformatf("empty_res %b, expected %b (bin %0d)",
                                  empty_res, want.no_ref, want.index));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bins_due.delete();
      clear_histogram();
      axis = AXIS_MODE_RESET;
      scale = BIN_SCALE_RESET;
      ref_kind = REFERENCE_TYPE_RESET;
    end else begin
      if (out_valid && !out_stall) compare_beat();
      if (cfg_write) begin
        case (cfg_index)
          REG_AXIS_MODE:      axis = cfg_data[MODE_W-1:0];
          REG_BIN_SCALE:      scale = cfg_data[SCALE_W-1:0];
          REG_REFERENCE_TYPE: ref_kind = cfg_data[TYPE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) fold_particle();
    end
    pending = bins_due.size();
  end

endmodule

// File: bench/particle_velocity_histogram_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_velocity_histogram_tb - stimulus and verdict for the histogram block
// Drives particle beats and register writes on the falling edge: a directed
// set of edge cases, an output hold-off that backs the block up, then random
// phases over every axis mode and a spread of bin scales and reference types,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module particle_velocity_histogram_tb;
  import pvh_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int SETTLE         = 3 * BINS_DEFAULT + 50;
  localparam int LIMIT_NS       = 15_000_000;
  localparam int RANDOM_ITEMS   = 120;
  localparam int HOLD_OFF       = 400;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [TYPE_W-1:0]          particle_type;
  logic                       pinned;
  logic signed [VEL_W-1:0]    vel_x, vel_y, vel_z;
  logic                       last_particle;
  logic                       out_valid;
  logic                       out_stall;
  logic [OUT_INDEX_W-1:0]     bin_index;
  logic [OUT_COUNT_W-1:0]     bin_count;
  logic                       last_bin;
  logic                       empty_res;
  logic                       cfg_write;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  int errors, pending, results;
  int particles_sent = 0;
  int readouts = 0;
  bit quiet = 1'b1;
  bit hold_off_req = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  particle_velocity_histogram dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .particle_type(particle_type), .pinned(pinned),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .last_particle(last_particle),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_index(bin_index), .bin_count(bin_count),
    .last_bin(last_bin), .empty_res(empty_res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  particle_velocity_histogram_checker histogram_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .particle_type(particle_type), .pinned(pinned),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .last_particle(last_particle),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_index(bin_index), .bin_count(bin_count),
    .last_bin(last_bin), .empty_res(empty_res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results(results)
  );

  initial begin
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stall runs, plus one long hold-off on request
  initial begin
    int run, hold, r;
    out_stall = 1'b0;
    run = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_OFF;
      end
      if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else if (quiet) begin
        out_stall = 1'b0;
      end else if (run > 0) begin
        run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall = 1'b0;
          run = $urandom_range(0, 5);
        end else if (r < 92) begin
          out_stall = 1'b1;
          run = $urandom_range(0, 2);
        end else begin
          out_stall = 1'b1;
          run = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mostly values that land near the emitted bin range, sometimes anything
  function automatic logic signed [VEL_W-1:0] pick_vel(input logic [SCALE_W-1:0] sc,
                                                       input bit speed);
    int lim;
    if ($urandom_range(0, 7) == 0) return VEL_W'($urandom);
    lim = (sc == 0) ? 32767 : 70 * 65536 / sc;
    if (lim > 32767) lim = 32767;
    if (speed) lim = lim / 2;
    return VEL_W'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  // entered and left on a falling edge
  task automatic offer_particle(input logic [TYPE_W-1:0] ptype, input logic fixed,
                                input logic signed [VEL_W-1:0] vx,
                                input logic signed [VEL_W-1:0] vy,
                                input logic signed [VEL_W-1:0] vz, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    particle_type = ptype;
    pinned = fixed;
    vel_x = vx;
    vel_y = vy;
    vel_z = vz;
    last_particle = last;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    particles_sent++;
    if (last) readouts++;
  endtask

  // wait for every owed beat, then let the clearing pass finish
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic program_regs(input logic [MODE_W-1:0] mode, input logic [SCALE_W-1:0] sc,
                              input logic [TYPE_W-1:0] rt);
    cfg_write = 1'b1;
    cfg_index = REG_AXIS_MODE;
    cfg_data = CFG_DATA_W'(mode);
    @(negedge clk);
    cfg_index = REG_BIN_SCALE;
    cfg_data = sc;
    @(negedge clk);
    cfg_index = REG_REFERENCE_TYPE;
    cfg_data = CFG_DATA_W'(rt);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    int                      p, n, seqs, len, random_sent, failures;
    bit                      noise, no_ref;
    logic [MODE_W-1:0]       mode;
    logic [SCALE_W-1:0]      sc;
    logic [TYPE_W-1:0]       rt, ptype;
    logic                    fixed;
    logic signed [VEL_W-1:0] vx, vy, vz;

    rst = 1'b1;
    in_valid = 1'b0;
    particle_type = '0;
    pinned = 1'b0;
    vel_x = '0;
    vel_y = '0;
    vel_z = '0;
    last_particle = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    repeat (SETTLE) @(negedge clk);

    // reset registers: speed, width 0.1, reference type 14
    offer_particle(8'd3, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b1);       // no reference seen
    offer_particle(8'd14, 1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1);      // fixed reference only
    offer_particle(8'd14, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    offer_particle(8'd14, 1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    offer_particle(8'd14, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    offer_particle(8'd200, 1'b0, 16'sd256, 16'sd0, 16'sd0, 1'b0);
    offer_particle(8'd14, 1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    offer_particle(8'd7, 1'b0, 16'sd0, -16'sd256, 16'sd0, 1'b1);    // full 64-bin readout
    settle();

    quiet = 1'b0;
    program_regs(MODE_X, 16'hFFFF, 8'd255);
    offer_particle(8'd255, 1'b0, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0);  // above top bin
    offer_particle(8'd255, 1'b0, 16'sh8000, 16'sd0, 16'sd0, 1'b0);  // negative bin
    offer_particle(8'd0, 1'b0, 16'sd1, 16'sd0, 16'sd0, 1'b0);
    offer_particle(8'd255, 1'b0, 16'sd16, 16'sd0, 16'sd0, 1'b1);
    settle();

    program_regs(MODE_Y, 16'd1, 8'd0);
    offer_particle(8'd0, 1'b0, 16'sd5, -16'sd1, 16'sd0, 1'b0);
    offer_particle(8'd0, 1'b0, 16'sd0, 16'sh7FFF, 16'sd0, 1'b1);
    settle();

    program_regs(MODE_Z, 16'd0, 8'd128);                           // zero scale
    offer_particle(8'd128, 1'b0, 16'sd0, 16'sd0, 16'sh8000, 1'b0);
    offer_particle(8'd1, 1'b0, 16'sd0, 16'sd0, 16'sh7FFF, 1'b1);
    settle();

    program_regs(MODE_Z, 16'd256, 8'd14);
    offer_particle(8'd14, 1'b0, 16'sd0, 16'sd0, 16'sd16383, 1'b0);
    offer_particle(8'd14, 1'b0, 16'sd0, 16'sd0, 16'sd16384, 1'b0);
    offer_particle(8'd9, 1'b0, 16'sd0, 16'sd0, 16'sd1280, 1'b1);
    settle();

    // result side held off while short readouts keep arriving
    quiet = 1'b0;
    program_regs(MODE_X, 16'd4096, 8'd14);
    hold_off_req = 1'b1;
    repeat (12) begin
      offer_particle(8'd14, 1'b0, VEL_W'($urandom_range(0, 300)), 16'sd0, 16'sd0, 1'b0);
      offer_particle(8'($urandom), 1'b0, VEL_W'($urandom_range(0, 300)),
                     VEL_W'($urandom), VEL_W'($urandom), 1'b1);
    end
    settle();

    random_sent = 0;
    p = 0;
    while (random_sent < RANDOM_ITEMS) begin
      mode = MODE_W'(p % 4);
      case (p % 6)
        0:       sc = 16'd2560;
        1:       sc = 16'hFFFF;
        2:       sc = 16'd1;
        3:       sc = SCALE_W'($urandom_range(1, 65535));
        4:       sc = SCALE_W'(256 * $urandom_range(1, 40));
        default: sc = SCALE_W'($urandom_range(64, 8192));
      endcase
      case (p % 5)
        0:       rt = 8'd0;
        1:       rt = 8'd255;
        default: rt = 8'($urandom);
      endcase
      quiet = (p % 4 == 3);
      program_regs(mode, sc, rt);
      seqs = $urandom_range(1, 4);
      repeat (seqs) begin
        noise = ($urandom_range(0, 9) == 0);
        no_ref = ($urandom_range(0, 9) == 0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
        for (n = 0; n < len; n++) begin
          ptype = (!no_ref && $urandom_range(0, 1) == 1) ? rt : 8'($urandom);
          if (no_ref && ptype == rt) ptype = rt ^ 8'h01;
          fixed = ($urandom_range(0, 9) == 0);
          if (noise) begin
            vx = VEL_W'($urandom);
            vy = VEL_W'($urandom);
            vz = VEL_W'($urandom);
          end else begin
            vx = pick_vel(sc, mode == MODE_SPEED);
            vy = pick_vel(sc, mode == MODE_SPEED);
            vz = pick_vel(sc, mode == MODE_SPEED);
          end
          offer_particle(ptype, fixed, vx, vy, vz, n == len - 1);
          if (!fixed || n == len - 1) random_sent++;
        end
      end
      settle();
      p++;
    end

    failures = errors + pending;
    $display("Sent %0d particles in %0d readouts; %0d result beats checked.",
             particles_sent, readouts, results);
    $display("All axis modes, scales 0 to 65535, a %0d-cycle result hold-off.",
             HOLD_OFF);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/pvh_pkg.sv
sv/pvh_fifo.sv
sv/pvh_front.sv
sv/pvh_back.sv
sv/particle_velocity_histogram.sv
bench/particle_velocity_histogram_checker.sv
bench/particle_velocity_histogram_tb.sv
